/* hdl/longest_hit_run_clusterizer_macros.svh */
// Assertion macros of the clusterizer RTL, used by its top level.
`ifndef LONGEST_HIT_RUN_CLUSTERIZER_MACROS_SVH
`define LONGEST_HIT_RUN_CLUSTERIZER_MACROS_SVH

// General clocked check, inactive while reset is asserted.
`define LHRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on the result register contents while a result is offered.
`define LHRC_ASSERT_RESULT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		result.valid |-> (expr)) else $error(msg);

`endif

/* hdl/lhrc_pkg.sv */
// Package with the shared types and constants of the hit run clusterizer.
`timescale 1ns / 1ps
`default_nettype none
package lhrc_pkg;

	localparam int COORD_W    = 11;
	localparam int GAP_W      = 8;
	localparam int LEN_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_STATION = 2'd2;

	localparam logic [GAP_W-1:0] GAP_LIMIT_RST  = 8'd2;
	localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 11'd3;
	localparam logic [GAP_W-1:0] GAP_SAT        = 8'hFF;
	localparam logic [1:0]       HIT_SAT        = 2'd2;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] first_ch;
		logic [COORD_W-1:0] last_ch;
		logic               single;
	} view_res_t;

endpackage
`default_nettype wire

/* hdl/lhrc_channels.sv */
// Channel interfaces of the clusterizer: channel items, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface lhrc_chan_if;
	logic valid;
	logic ready;
	logic hit_x;
	logic hit_y;
	logic last_channel;

	modport source (output valid, output hit_x, output hit_y, output last_channel,
		input ready);
	modport sink (input valid, input hit_x, input hit_y, input last_channel,
		output ready);
endinterface

interface lhrc_result_if;
	import lhrc_pkg::*;
	logic               valid;
	logic               ready;
	logic               skipped;
	logic               found_x;
	logic [COORD_W-1:0] begin_x;
	logic [COORD_W-1:0] end_x;
	logic               found_y;
	logic [COORD_W-1:0] begin_y;
	logic [COORD_W-1:0] end_y;
	logic               both_found;

	modport source (output valid, output skipped, output found_x, output begin_x,
		output end_x, output found_y, output begin_y, output end_y, output both_found,
		input ready);
	modport sink (input valid, input skipped, input found_x, input begin_x,
		input end_x, input found_y, input begin_y, input end_y, input both_found,
		output ready);
endinterface

interface lhrc_cfg_if;
	import lhrc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/longest_hit_run_clusterizer.sv */
// Top level of the gap-tolerant longest hit run clusterizer for one two-view plane.
`timescale 1ns / 1ps
`default_nettype none
`include "longest_hit_run_clusterizer_macros.svh"
// The block takes one channel per clock cycle, in index order, and updates the
// run trackers of both views in the cycle of the transfer. The transfer of the
// channel flagged last_channel loads the result register, so the result is
// offered on the following cycle and the plane state starts over at channel
// zero. Channels are accepted whenever the result register is empty or is
// being emptied in the same cycle, which allows back-to-back planes. Register
// writes are always accepted and apply from the next cycle.
module longest_hit_run_clusterizer #(
	parameter int CHANNELS = 1536
) (
	input wire logic      clk,
	input wire logic      arst_n,
	lhrc_chan_if.sink     chan,
	lhrc_result_if.source result,
	lhrc_cfg_if.sink      cfg
);
	import lhrc_pkg::*;

	localparam int CH_W  = $clog2(CHANNELS);
	localparam int CNT_W = $clog2(CHANNELS + 1);

	logic [GAP_W-1:0] gap_limit_q;
	logic [LEN_W-1:0] min_length_q;
	logic             first_station_q;
	logic [CNT_W-1:0] chan_idx_q;
	logic             chan_xfer;
	logic             step;
	logic             plane_end;
	logic             skip;
	view_res_t        res_x;
	view_res_t        res_y;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q     <= GAP_LIMIT_RST;
			min_length_q    <= MIN_LENGTH_RST;
			first_station_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GAP_LIMIT:     gap_limit_q     <= cfg.data[GAP_W-1:0];
				REG_MIN_LENGTH:    min_length_q    <= cfg.data[LEN_W-1:0];
				REG_FIRST_STATION: first_station_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign chan.ready = !result.valid || result.ready;
	assign chan_xfer  = chan.valid && chan.ready;
	assign step       = chan_xfer && (chan_idx_q < CNT_W'(CHANNELS));
	assign plane_end  = chan_xfer && chan.last_channel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_idx_q <= '0;
		end else if (plane_end) begin
			chan_idx_q <= '0;
		end else if (step) begin
			chan_idx_q <= chan_idx_q + CNT_W'(1);
		end
	end

	lhrc_view #(.CHANNELS(CHANNELS)) u_view_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.clear      (plane_end),
		.hit        (chan.hit_x),
		.ch         (chan_idx_q[CH_W-1:0]),
		.gap_limit  (gap_limit_q),
		.min_length (min_length_q),
		.res        (res_x)
	);

	lhrc_view #(.CHANNELS(CHANNELS)) u_view_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.clear      (plane_end),
		.hit        (chan.hit_y),
		.ch         (chan_idx_q[CH_W-1:0]),
		.gap_limit  (gap_limit_q),
		.min_length (min_length_q),
		.res        (res_y)
	);

	assign skip = first_station_q && res_x.single && res_y.single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (plane_end) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (plane_end) begin
			result.skipped    <= skip;
			result.found_x    <= !skip && res_x.found;
			result.begin_x    <= (!skip && res_x.found) ? res_x.first_ch : '0;
			result.end_x      <= (!skip && res_x.found) ? res_x.last_ch : '0;
			result.found_y    <= !skip && res_y.found;
			result.begin_y    <= (!skip && res_y.found) ? res_y.first_ch : '0;
			result.end_y      <= (!skip && res_y.found) ? res_y.last_ch : '0;
			result.both_found <= !skip && res_x.found && res_y.found;
		end
	end

	`LHRC_ASSERT(a_plane_end_gives_result, chan.valid && chan.ready && chan.last_channel |=> result.valid, "No result after the last channel of a plane.")
	`LHRC_ASSERT(a_idx_in_range, chan_idx_q <= CNT_W'(CHANNELS), "Channel index ran past the channel count.")
	`LHRC_ASSERT_RESULT(a_skip_clears_fields, !result.skipped || (!result.found_x && !result.found_y && !result.both_found), "Skipped result reports a cluster.")
	`LHRC_ASSERT_RESULT(a_both_consistent, result.both_found == (result.found_x && result.found_y), "both_found disagrees with the view flags.")

endmodule
`default_nettype wire

/* hdl/lhrc_view.sv */
// Run tracker of one view: open run, gap counter, longest run and hit count.
`timescale 1ns / 1ps
`default_nettype none
module lhrc_view #(
	parameter int CHANNELS = 1536
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        clear,
	input  wire logic                        hit,
	input  wire logic [$clog2(CHANNELS)-1:0] ch,
	input  wire logic [lhrc_pkg::GAP_W-1:0]  gap_limit,
	input  wire logic [lhrc_pkg::LEN_W-1:0]  min_length,
	output lhrc_pkg::view_res_t              res
);
	import lhrc_pkg::*;

	localparam int CH_W  = $clog2(CHANNELS);
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic             open_q, open_d;
	logic [CH_W-1:0]  start_q, start_d;
	logic [CH_W-1:0]  best_start_q, best_start_d;
	logic [CH_W-1:0]  best_end_q, best_end_d;
	logic [CNT_W-1:0] best_len_q, best_len_d;
	logic [GAP_W-1:0] gap_q, gap_d;
	logic [1:0]       hits_q, hits_d;
	logic [CNT_W-1:0] run_len;

	always_comb begin
		open_d       = open_q;
		start_d      = start_q;
		best_start_d = best_start_q;
		best_end_d   = best_end_q;
		best_len_d   = best_len_q;
		gap_d        = gap_q;
		hits_d       = hits_q;
		run_len      = '0;
		if (step) begin
			if (hit) begin
				open_d = 1'b1;
				if (!open_q) begin
					start_d = ch;
				end
				run_len = CNT_W'(ch) - CNT_W'(start_d) + CNT_W'(1);
				if (run_len > best_len_q) begin
					best_len_d   = run_len;
					best_start_d = start_d;
					best_end_d   = ch;
				end
				gap_d = '0;
				if (hits_q != HIT_SAT) begin
					hits_d = hits_q + 2'd1;
				end
			end else begin
				if (gap_q >= gap_limit) begin
					open_d = 1'b0;
				end
				if (gap_q != GAP_SAT) begin
					gap_d = gap_q + GAP_W'(1);
				end
			end
		end
	end

	always_comb begin
		res.found    = (best_len_d != '0) && (CMP_W'(best_len_d) >= CMP_W'(min_length));
		res.first_ch = COORD_W'(best_start_d);
		res.last_ch  = COORD_W'(best_end_d);
		res.single   = (hits_d == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			start_q      <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			best_len_q   <= '0;
			gap_q        <= '0;
			hits_q       <= '0;
		end else if (clear) begin
			open_q       <= 1'b0;
			start_q      <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			best_len_q   <= '0;
			gap_q        <= '0;
			hits_q       <= '0;
		end else if (step) begin
			open_q       <= open_d;
			start_q      <= start_d;
			best_start_q <= best_start_d;
			best_end_q   <= best_end_d;
			best_len_q   <= best_len_d;
			gap_q        <= gap_d;
			hits_q       <= hits_d;
		end
	end

endmodule
`default_nettype wire

/* tb/longest_hit_run_clusterizer_tb.sv */
// Self-checking testbench of the hit run clusterizer: directed and random planes under stalls.
`timescale 1ns / 1ps
module longest_hit_run_clusterizer_tb;
	import lhrc_pkg::*;

	localparam int CHANNELS = 1536;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int WIDE_PLANE = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {SHAPE_RANDOM, SHAPE_RUNS, SHAPE_SINGLE, SHAPE_EMPTY} hit_shape_t;

	typedef struct packed {
		logic hit_x;
		logic hit_y;
		logic last_channel;
	} channel_t;

	typedef struct packed {
		logic               skipped;
		logic               found_x;
		logic [COORD_W-1:0] begin_x;
		logic [COORD_W-1:0] end_x;
		logic               found_y;
		logic [COORD_W-1:0] begin_y;
		logic [COORD_W-1:0] end_y;
		logic               both_found;
	} cluster_t;

	logic clk;
	logic arst_n;

	lhrc_chan_if   chan_bus();
	lhrc_result_if res_bus();
	lhrc_cfg_if    cfg_bus();

	longest_hit_run_clusterizer #(.CHANNELS(CHANNELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.chan(chan_bus),
		.result(res_bus),
		.cfg(cfg_bus)
	);

	channel_t channel_q[$];
	cluster_t expected_clusters[$];
	channel_t next_item;
	cluster_t got_cluster;
	cluster_t want_cluster;

	int items_queued;
	int items_taken;
	int fault_count;
	int idle_cycles;
	int burst_left;
	int gap_left;
	int hold_ticket;
	int hold_seen;
	int hold_left;
	int stall_mode;
	int stall_left;

	// Register copies and per-plane run tracking of both views.
	logic [GAP_W-1:0]   gap_lim;
	logic [LEN_W-1:0]   min_len;
	logic               first_st;
	logic [COORD_W-1:0] plane_ch;
	logic               open_run[2];
	logic [COORD_W-1:0] run_first[2];
	logic [COORD_W-1:0] best_first[2];
	logic [COORD_W-1:0] best_last[2];
	logic [LEN_W-1:0]   best_len[2];
	logic [GAP_W-1:0]   gap_run[2];
	logic [1:0]         hit_tally[2];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_plane();
		plane_ch = '0;
		for (int v = 0; v < 2; v++) begin
			open_run[v] = 1'b0;
			run_first[v] = '0;
			best_first[v] = '0;
			best_last[v] = '0;
			best_len[v] = '0;
			gap_run[v] = '0;
			hit_tally[v] = '0;
		end
	endfunction

	task automatic advance_view(input int v, input logic hit, input logic [COORD_W-1:0] ch);
		logic [LEN_W-1:0] span;
		if (hit) begin
			if (!open_run[v]) begin
				open_run[v] = 1'b1;
				run_first[v] = ch;
			end
			span = ch - run_first[v] + 1'b1;
			if (span > best_len[v]) begin
				best_len[v] = span;
				best_first[v] = run_first[v];
				best_last[v] = ch;
			end
			gap_run[v] = '0;
			if (hit_tally[v] < HIT_SAT)
				hit_tally[v] = hit_tally[v] + 1'b1;
		end else begin
			if (gap_run[v] >= gap_lim)
				open_run[v] = 1'b0;
			if (gap_run[v] != GAP_SAT)
				gap_run[v] = gap_run[v] + 1'b1;
		end
	endtask

	task automatic absorb_channel(input channel_t item);
		cluster_t rec;
		logic fx;
		logic fy;
		if (plane_ch < CHANNELS) begin
			advance_view(0, item.hit_x, plane_ch);
			advance_view(1, item.hit_y, plane_ch);
			plane_ch = plane_ch + 1'b1;
		end
		if (item.last_channel) begin
			rec = '0;
			if (first_st && hit_tally[0] == 2'd1 && hit_tally[1] == 2'd1) begin
				rec.skipped = 1'b1;
			end else begin
				fx = (best_len[0] != '0) && (best_len[0] >= min_len);
				fy = (best_len[1] != '0) && (best_len[1] >= min_len);
				if (fx) begin
					rec.found_x = 1'b1;
					rec.begin_x = best_first[0];
					rec.end_x = best_last[0];
				end
				if (fy) begin
					rec.found_y = 1'b1;
					rec.begin_y = best_first[1];
					rec.end_y = best_last[1];
				end
				rec.both_found = fx && fy;
			end
			expected_clusters.insert(expected_clusters.size(), rec);
			clear_plane();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_GAP_LIMIT: gap_lim = val[GAP_W-1:0];
			REG_MIN_LENGTH: min_len = val[LEN_W-1:0];
			REG_FIRST_STATION: first_st = val[0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic push_item(input logic hx, input logic hy, input logic last);
		channel_q.insert(channel_q.size(), channel_t'({hx, hy, last}));
		items_queued++;
	endtask

	task automatic push_pattern(input int n, input logic [31:0] xs, input logic [31:0] ys);
		for (int ch = 0; ch < n; ch++)
			push_item(xs[ch], ys[ch], ch == n - 1);
	endtask

	task automatic push_plane(input int n);
		hit_shape_t shape[2];
		int dens[2];
		int wait_ch[2];
		int spot[2];
		int reach;
		int pick;
		logic h[2];
		reach = (gap_lim > 10) ? 10 : gap_lim;
		for (int v = 0; v < 2; v++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				shape[v] = SHAPE_RANDOM;
			else if (pick < 8)
				shape[v] = SHAPE_RUNS;
			else if (pick == 8)
				shape[v] = SHAPE_SINGLE;
			else
				shape[v] = SHAPE_EMPTY;
			dens[v] = $urandom_range(5, 95);
			wait_ch[v] = $urandom_range(0, n);
			spot[v] = $urandom_range(0, n - 1);
		end
		if ($urandom_range(0, 7) == 0) begin
			shape[0] = SHAPE_SINGLE;
			shape[1] = SHAPE_SINGLE;
		end
		for (int ch = 0; ch < n; ch++) begin
			for (int v = 0; v < 2; v++) begin
				case (shape[v])
					SHAPE_RANDOM: h[v] = $urandom_range(0, 99) < dens[v];
					SHAPE_RUNS: begin
						h[v] = wait_ch[v] == 0;
						if (h[v])
							wait_ch[v] = ($urandom_range(0, 3) != 0) ?
								$urandom_range(0, reach + 1) : $urandom_range(0, 24);
						else
							wait_ch[v]--;
					end
					SHAPE_SINGLE: h[v] = ch == spot[v];
					default: h[v] = 1'b0;
				endcase
			end
			push_item(h[0], h[1], ch == n - 1);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (items_taken != items_queued || expected_clusters.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_bus.valid <= 1'b0;
			chan_bus.hit_x <= 1'b0;
			chan_bus.hit_y <= 1'b0;
			chan_bus.last_channel <= 1'b0;
		end else begin
			if (chan_bus.valid && chan_bus.ready) begin
				absorb_channel({chan_bus.hit_x, chan_bus.hit_y, chan_bus.last_channel});
				items_taken++;
			end
			if (!chan_bus.valid || chan_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					chan_bus.valid <= 1'b0;
				end else if (channel_q.size() > 0) begin
					next_item = channel_q.pop_front();
					chan_bus.valid <= 1'b1;
					chan_bus.hit_x <= next_item.hit_x;
					chan_bus.hit_y <= next_item.hit_y;
					chan_bus.last_channel <= next_item.last_channel;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					chan_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (hold_seen != hold_ticket) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					stall_left = $urandom_range(16, 96);
				end
				stall_left--;
				case (stall_mode)
					0: res_bus.ready <= 1'b1;
					1: res_bus.ready <= 1'($urandom_range(0, 1));
					default: res_bus.ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got_cluster = {res_bus.skipped, res_bus.found_x, res_bus.begin_x, res_bus.end_x,
				res_bus.found_y, res_bus.begin_y, res_bus.end_y, res_bus.both_found};
			if (expected_clusters.size() == 0) begin
				if (fault_count < 10)
					$display("unexpected result: skip=%0b fx=%0b x=%0d..%0d fy=%0b y=%0d..%0d b=%0b",
						got_cluster.skipped, got_cluster.found_x, got_cluster.begin_x,
						got_cluster.end_x, got_cluster.found_y, got_cluster.begin_y,
						got_cluster.end_y, got_cluster.both_found);
				fault_count++;
			end else begin
				want_cluster = expected_clusters.pop_front();
				if (got_cluster !== want_cluster) begin
					if (fault_count < 10) begin
						$display("cluster mismatch at %0t", $realtime);
						$display("  expected skip=%0b fx=%0b x=%0d..%0d fy=%0b y=%0d..%0d both=%0b",
							want_cluster.skipped, want_cluster.found_x, want_cluster.begin_x,
							want_cluster.end_x, want_cluster.found_y, want_cluster.begin_y,
							want_cluster.end_y, want_cluster.both_found);
						$display("  actual   skip=%0b fx=%0b x=%0d..%0d fy=%0b y=%0d..%0d both=%0b",
							got_cluster.skipped, got_cluster.found_x, got_cluster.begin_x,
							got_cluster.end_x, got_cluster.found_y, got_cluster.begin_y,
							got_cluster.end_y, got_cluster.both_found);
					end
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chan_bus.valid && chan_bus.ready) || (res_bus.valid && res_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int budget;
		int g;
		int m;
		int f;
		logic hx;
		logic hy;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_GAP_LIMIT;
		cfg_bus.data = '0;
		gap_lim = GAP_LIMIT_RST;
		min_len = MIN_LENGTH_RST;
		first_st = 1'b0;
		clear_plane();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: lone hit, tolerated gap, closed run, tie, full view.
		push_pattern(1, 32'h1, 32'h0);
		push_pattern(8, 32'b0000_1001, 32'b1000_0111);
		push_pattern(10, 32'b01_1100_0111, 32'h3FF);
		push_pattern(1, 32'h1, 32'h1);
		wait_drained();
		write_reg(REG_GAP_LIMIT, 11'd0);
		write_reg(REG_MIN_LENGTH, 11'd1);
		write_reg(REG_FIRST_STATION, 11'd1);
		write_reg(REG_UNUSED, 11'h7FF);
		push_pattern(3, 32'b010, 32'b001);
		push_pattern(2, 32'b11, 32'b01);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin g = 0; m = 1; f = 0; end
				1: begin g = 255; m = WIDE_PLANE; f = 1; end
				2: begin g = 1; m = 0; f = 1; end
				3: begin g = 2; m = 2047; f = 0; end
				4: begin g = 3; m = 4; f = 0; end
				default: begin
					g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 8);
					m = $urandom_range(0, 12);
					f = $urandom_range(0, 3);
				end
			endcase
			write_reg(REG_GAP_LIMIT, CFG_DATA_W'(g));
			write_reg(REG_MIN_LENGTH, CFG_DATA_W'(m));
			write_reg(REG_FIRST_STATION, CFG_DATA_W'(f));
			if (p == 1) begin
				// A gap of exactly 255 keeps the x run open across the plane; in the y
				// view a gap of 256 saturates the gap counter and closes the run.
				for (int ch = 0; ch < WIDE_PLANE; ch++) begin
					hx = ch == 0 || ch == 256 || ch == WIDE_PLANE - 1;
					hy = ch == 0 || (ch >= 257 && ch <= 260) || (ch >= 280 && ch != 290);
					push_item(hx, hy, ch == WIDE_PLANE - 1);
				end
			end
			if (p == 4) begin
				@(posedge clk);
				hold_ticket <= hold_ticket + 1;
				for (int k = 0; k < 40; k++)
					push_plane($urandom_range(1, 3));
			end else begin
				budget = items_queued + 30;
				while (items_queued < budget)
					push_plane(($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) :
						$urandom_range(1, 24));
			end
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (fault_count == 0 && expected_clusters.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/lhrc_pkg.sv
hdl/lhrc_channels.sv
hdl/lhrc_view.sv
hdl/longest_hit_run_clusterizer.sv
tb/longest_hit_run_clusterizer_tb.sv
